### hdl/rcrt_pkg.sv
`timescale 1ns / 1ps

package rcrt_pkg;

  // Default sizes of the function table and the shadow stack.
  localparam int unsigned FUNC_SLOTS_DEF  = 64;
  localparam int unsigned STACK_DEPTH_DEF = 128;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_TRACE_ENABLE   = 1'b0;
  localparam logic REG_FUNCTION_COUNT = 1'b1;

  // Input operations and result kinds.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRACE = 1'b1;
  localparam logic EV_CALL  = 1'b0;
  localparam logic EV_RET   = 1'b1;

  // Instruction decoding.
  localparam logic [6:0] OPC_JAL  = 7'b1101111;
  localparam logic [6:0] OPC_JALR = 7'b1100111;
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;

  // One shadow stack frame: found flag, table index, function start.
  localparam int unsigned FIDX_W  = 6;
  localparam int unsigned FRAME_W = 1 + FIDX_W + 32;

  typedef struct packed {
    logic capture;
    logic table_write;
    logic search_start;
    logic search_step;
    logic push;
    logic pop_read;
    logic pop_use;
    logic emit;
  } rcrt_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_call;
    logic is_ret;
    logic trace_en;
    logic stack_empty;
    logic search_done;
    logic out_free;
  } rcrt_status_t;

endpackage

### hdl/rcrt_ram.sv
`timescale 1ns / 1ps

module rcrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rcrt_ctrl.sv
`timescale 1ns / 1ps

module rcrt_ctrl import rcrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  rcrt_status_t status_i,
  output rcrt_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_POP    = 5'b01000,
    ST_EMIT   = 5'b10000
  } rcrt_state_e;

  rcrt_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_load) begin
          cmd_o.table_write = 1'b1;
          state_d           = ST_IDLE;
        end else if (!status_i.trace_en) begin
          state_d = ST_IDLE;
        end else if (status_i.is_call) begin
          cmd_o.search_start = 1'b1;
          state_d            = ST_SEARCH;
        end else if (status_i.is_ret && !status_i.stack_empty) begin
          cmd_o.pop_read = 1'b1;
          state_d        = ST_POP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (status_i.search_done) begin
          cmd_o.push = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      ST_POP: begin
        cmd_o.pop_use = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### hdl/rcrt_dp.sv
`timescale 1ns / 1ps

module rcrt_dp import rcrt_pkg::*; #(
  parameter int unsigned FUNC_SLOTS  = FUNC_SLOTS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcrt_cmd_t         cmd_i,
  output rcrt_status_t      status_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  input  logic              operation_i,
  input  logic [5:0]        entry_index_i,
  input  logic [31:0]       entry_start_i,
  input  logic [31:0]       entry_end_i,
  input  logic [31:0]       pc_i,
  input  logic [31:0]       inst_i,
  input  logic [31:0]       rs1_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              event_kind_o,
  output logic [31:0]       event_pc_o,
  output logic [31:0]       jump_target_o,
  output logic              func_found_o,
  output logic [5:0]        func_index_o,
  output logic [31:0]       callee_start_o,
  output logic [7:0]        stack_depth_o,
  output logic              recorded_o
);

  localparam int unsigned TAW = (FUNC_SLOTS > 1) ? $clog2(FUNC_SLOTS) : 1;
  localparam int unsigned LW  = $clog2(FUNC_SLOTS + 1);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam logic [12:0] SLOTS13 = 13'(FUNC_SLOTS);

  // Configuration registers.
  logic       trace_en_q;
  logic [6:0] func_count_q;

  // Captured input word.
  logic        op_q;
  logic [5:0]  eidx_q;
  logic [31:0] estart_q, eend_q, pc_q, inst_q, rs1v_q;

  // Search and result state.
  logic [31:0]      target_q;
  logic [LW-1:0]    iss_q;
  logic             chk_v_q;
  logic [TAW-1:0]   chk_idx_q;
  logic             done_q;
  logic             res_kind_q, res_found_q, res_rec_q;
  logic [FIDX_W-1:0] res_idx_q;
  logic [31:0]      res_start_q;
  logic [SCW-1:0]   depth_q;

  // Output register.
  logic        out_valid_q;
  logic        ev_kind_q, ev_found_q, ev_rec_q;
  logic [31:0] ev_pc_q, ev_target_q, ev_start_q;
  logic [5:0]  ev_idx_q;
  logic [7:0]  ev_depth_q;

  // Decode of the captured instruction.
  logic [6:0]  opc;
  logic [4:0]  rd_f, rs1_f;
  logic [11:0] imm12;
  logic        is_jal, is_jalr, is_ret, is_call;
  logic [31:0] jimm, iimm, target_jal, target_jalr, target_sel;

  assign opc     = inst_q[6:0];
  assign rd_f    = inst_q[11:7];
  assign rs1_f   = inst_q[19:15];
  assign imm12   = inst_q[31:20];
  assign is_jal  = (opc == OPC_JAL);
  assign is_jalr = (opc == OPC_JALR);
  assign is_ret  = is_jalr && (rd_f == REG_ZERO) && (rs1_f == REG_RA) && (imm12 == 12'd0);
  assign is_call = is_jal || (is_jalr && !is_ret);
  assign jimm = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21], 1'b0};
  assign iimm = {{20{inst_q[31]}}, imm12};
  assign target_jal  = pc_q + jimm;
  assign target_jalr = (rs1v_q + iimm) & ~32'd1;
  assign target_sel  = is_jal ? target_jal : target_jalr;

  // Function table: one entry holds {end, start}.
  logic          tbl_we, tbl_re, slot_ok;
  logic [63:0]   tbl_rdata;
  logic [31:0]   rd_start, rd_end;
  logic [LW-1:0] limit;
  logic          iss_lt, hit;

  assign slot_ok  = (13'(eidx_q) < SLOTS13);
  assign tbl_we   = cmd_i.table_write && slot_ok;
  assign rd_start = tbl_rdata[31:0];
  assign rd_end   = tbl_rdata[63:32];
  assign limit    = (13'(func_count_q) < SLOTS13) ? LW'(func_count_q) : LW'(FUNC_SLOTS);
  assign iss_lt   = (iss_q < limit);
  assign hit      = chk_v_q && (target_q >= rd_start) && (target_q < rd_end);
  assign tbl_re   = cmd_i.search_step && !hit && iss_lt;

  rcrt_ram #(
    .WIDTH (64),
    .DEPTH (FUNC_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (TAW'(eidx_q)),
    .wdata_i ({eend_q, estart_q}),
    .re_i    (tbl_re),
    .raddr_i (iss_q[TAW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Shadow stack.
  logic               stk_full, stk_empty, stk_we;
  logic [SCW-1:0]     depth_m1;
  logic [FRAME_W-1:0] stk_rdata;
  logic               pop_found;

  assign stk_full  = (depth_q == SCW'(STACK_DEPTH));
  assign stk_empty = (depth_q == '0);
  assign stk_we    = cmd_i.push && !stk_full;
  assign depth_m1  = depth_q - SCW'(1);
  assign pop_found = stk_rdata[FRAME_W-1];

  rcrt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[SAW-1:0]),
    .wdata_i ({res_found_q, res_idx_q, res_start_q}),
    .re_i    (cmd_i.pop_read),
    .raddr_i (depth_m1[SAW-1:0]),
    .rdata_o (stk_rdata)
  );

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_en_q   <= 1'b0;
      func_count_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TRACE_ENABLE:   trace_en_q   <= pwdata[0];
        REG_FUNCTION_COUNT: func_count_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_FUNCTION_COUNT) ? CFG_DW'(func_count_q)
                                                   : CFG_DW'(trace_en_q);

  // Input capture and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      eidx_q   <= entry_index_i;
      estart_q <= entry_start_i;
      eend_q   <= entry_end_i;
      pc_q     <= pc_i;
      inst_q   <= inst_i;
      rs1v_q   <= rs1_value_i;
    end
    if (cmd_i.search_start) begin
      target_q   <= target_sel;
      res_kind_q <= EV_CALL;
    end
    if (cmd_i.search_step) begin
      if (hit) begin
        res_found_q <= 1'b1;
        res_idx_q   <= FIDX_W'(chk_idx_q);
        res_start_q <= rd_start;
      end else if (iss_lt) begin
        chk_idx_q <= iss_q[TAW-1:0];
      end else begin
        res_found_q <= 1'b0;
        res_idx_q   <= '0;
        res_start_q <= '0;
      end
    end
    if (cmd_i.push) begin
      res_rec_q <= !stk_full;
    end
    if (cmd_i.pop_read) begin
      res_kind_q <= EV_RET;
      res_rec_q  <= 1'b1;
    end
    if (cmd_i.pop_use) begin
      res_found_q <= pop_found;
      res_idx_q   <= pop_found ? stk_rdata[FRAME_W-2:32] : '0;
      res_start_q <= pop_found ? stk_rdata[31:0] : '0;
    end
    if (cmd_i.emit) begin
      ev_kind_q   <= res_kind_q;
      ev_pc_q     <= pc_q;
      ev_target_q <= (res_kind_q == EV_RET) ? 32'd0 : target_q;
      ev_found_q  <= res_found_q;
      ev_idx_q    <= res_idx_q;
      ev_start_q  <= res_start_q;
      ev_depth_q  <= 8'(depth_q);
      ev_rec_q    <= res_rec_q;
    end
  end

  // Search counters, stack depth and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q       <= '0;
      chk_v_q     <= 1'b0;
      done_q      <= 1'b0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.search_start) begin
        iss_q   <= '0;
        chk_v_q <= 1'b0;
        done_q  <= 1'b0;
      end else if (cmd_i.search_step) begin
        if (hit || !iss_lt) begin
          done_q <= 1'b1;
        end else begin
          chk_v_q <= 1'b1;
          iss_q   <= iss_q + LW'(1);
        end
      end
      if (stk_we) begin
        depth_q <= depth_q + SCW'(1);
      end else if (cmd_i.pop_read) begin
        depth_q <= depth_m1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.is_load     = (op_q == OP_LOAD);
  assign status_o.is_call     = (op_q == OP_TRACE) && is_call;
  assign status_o.is_ret      = (op_q == OP_TRACE) && is_ret;
  assign status_o.trace_en    = trace_en_q;
  assign status_o.stack_empty = stk_empty;
  assign status_o.search_done = done_q;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = ev_kind_q;
  assign event_pc_o     = ev_pc_q;
  assign jump_target_o  = ev_target_q;
  assign func_found_o   = ev_found_q;
  assign func_index_o   = ev_idx_q;
  assign callee_start_o = ev_start_q;
  assign stack_depth_o  = ev_depth_q;
  assign recorded_o     = ev_rec_q;

endmodule

### hdl/riscv_call_return_tracker_core.sv
`timescale 1ns / 1ps

// Call and return tracker for retired RV32 instructions.
// The input channel takes one word per item: either a load of a function
// table entry (slot, start, end) or a retired instruction with its pc and
// the value of its rs1 register. The output channel gives one word per
// reported call or return. Both channels use valid and stall.
// A load is written to the table in the decode state and yields no word. A
// traced instruction that is no call and no return yields no word either. A
// return on a non-empty stack reads the stack RAM in the decode state, takes
// the registered frame in the pop state and fills the output register in emit.
// A call searches the table in the search state, pushes a frame and fills
// the output register in the emit state; the search examines at most
// function_count entries, and never more than the table holds; the single
// read port of the table RAM checks one entry per cycle.
// Items are processed one at a time; a new word is accepted while a finished
// result still sits in the output register. If the receiver stalls, the
// result holds and the next result waits until the register is free.
// Reset clears the stack depth, both configuration registers and the output
// valid; the table and stack RAMs keep whatever they held.
// Configuration must be written through the APB port only while the block is idle; the block does not enforce this.

module riscv_call_return_tracker_core import rcrt_pkg::*; #(
  parameter int unsigned FUNC_SLOTS  = FUNC_SLOTS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [5:0]        entry_index_i,
  input  logic [31:0]       entry_start_i,
  input  logic [31:0]       entry_end_i,
  input  logic [31:0]       pc_i,
  input  logic [31:0]       inst_i,
  input  logic [31:0]       rs1_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              event_kind_o,
  output logic [31:0]       event_pc_o,
  output logic [31:0]       jump_target_o,
  output logic              func_found_o,
  output logic [5:0]        func_index_o,
  output logic [31:0]       callee_start_o,
  output logic [7:0]        stack_depth_o,
  output logic              recorded_o
);

  rcrt_cmd_t    cmd;
  rcrt_status_t status;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  // The controller sequences decode, table search, push and pop.
  rcrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the captured word, both RAMs and the output register.
  rcrt_dp #(
    .FUNC_SLOTS  (FUNC_SLOTS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .entry_start_i  (entry_start_i),
    .entry_end_i    (entry_end_i),
    .pc_i           (pc_i),
    .inst_i         (inst_i),
    .rs1_value_i    (rs1_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .event_pc_o     (event_pc_o),
    .jump_target_o  (jump_target_o),
    .func_found_o   (func_found_o),
    .func_index_o   (func_index_o),
    .callee_start_o (callee_start_o),
    .stack_depth_o  (stack_depth_o),
    .recorded_o     (recorded_o)
  );

endmodule

### hdl/rcrt_checker.sv
`timescale 1ns / 1ps

module rcrt_checker import rcrt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        event_kind_o,
  input logic [31:0] jump_target_o,
  input logic        func_found_o,
  input logic [5:0]  func_index_o,
  input logic [31:0] callee_start_o,
  input logic        recorded_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Items are worked one at a time, so an accepted word blocks the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted right after the first");

  // Returns carry no target and always pop a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_RET) |-> (jump_target_o == 32'd0) && recorded_o)
    else $error("malformed return word");

  // An unknown function reports index and start as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !func_found_o |-> (func_index_o == 6'd0) && (callee_start_o == 32'd0))
    else $error("unmatched function with nonzero index or start");

endmodule

bind riscv_call_return_tracker_core rcrt_checker u_rcrt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .event_kind_o   (event_kind_o),
  .jump_target_o  (jump_target_o),
  .func_found_o   (func_found_o),
  .func_index_o   (func_index_o),
  .callee_start_o (callee_start_o),
  .recorded_o     (recorded_o)
);
